// ===== hw/rtl/http_date_to_epoch_seconds_core_assert.svh =====
// Assertion helpers used by the date parser controller.
// Both sample on clk and are switched off while rst_n is low.
`ifndef HTTP_DATE_TO_EPOCH_SECONDS_CORE_ASSERT_SVH
`define HTTP_DATE_TO_EPOCH_SECONDS_CORE_ASSERT_SVH

// Same-cycle implication.
`define HDTE_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define HDTE_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hw/rtl/hdte_pkg.sv =====
package hdte_pkg;

    localparam int EPOCH_W = 39;
    localparam int TOD_W   = 17;
    localparam int DOY_W   = 9;

    localparam logic [7:0] CH_COMMA = 8'h2C;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_COLON = 8'h3A;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;

    // Reciprocal of 25 for an exact quotient of values below 43690.
    localparam int RECIP_25    = 5243;
    localparam int RECIP_SHIFT = 17;

    localparam int EPOCH_DAY_OFS = 719468;
    localparam int SECS_PER_DAY  = 86400;

    // Month names in lower case, first letter in the low byte.
    localparam logic [23:0] MONTH_WORD [12] = '{
        24'h6E616A, 24'h626566, 24'h72616D, 24'h727061,
        24'h79616D, 24'h6E756A, 24'h6C756A, 24'h677561,
        24'h706573, 24'h74636F, 24'h766F6E, 24'h636564
    };

    localparam logic [23:0] ZONE_WORD = 24'h746D67;

    // Day of year at the start of each month, counted from March.
    localparam logic [DOY_W-1:0] DOY_START [12] = '{
        9'd0, 9'd31, 9'd61, 9'd92, 9'd122, 9'd153,
        9'd184, 9'd214, 9'd245, 9'd275, 9'd306, 9'd337
    };

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PREP,
        ST_DIV,
        ST_DAYS,
        ST_MUL,
        ST_SUM
    } hdte_state_t;

    typedef struct packed {
        logic take_byte;
        logic capture;
        logic prep;
        logic div;
        logic days;
        logic mul;
        logic load_out;
    } hdte_cmd_t;

    typedef struct packed {
        logic       hit;
        logic [3:0] shifted;
        logic       jan_feb;
    } hdte_month_t;

    function automatic logic [7:0] to_lower(input logic [7:0] c);
        logic [7:0] r;
        r = c;
        if (c >= 8'h41 && c <= 8'h5A) begin
            r = c + 8'd32;
        end
        return r;
    endfunction

    // Looks up a month word; a March-based index and a Jan/Feb flag result.
    function automatic hdte_month_t month_lookup(input logic [23:0] w);
        hdte_month_t r;
        r = '0;
        for (int i = 0; i < 12; i++) begin
            if (w == MONTH_WORD[i]) begin
                r.hit = 1'b1;
                if (i < 2) begin
                    r.shifted = 4'(i + 10);
                    r.jan_feb = 1'b1;
                end else begin
                    r.shifted = 4'(i - 2);
                    r.jan_feb = 1'b0;
                end
            end
        end
        return r;
    endfunction

endpackage

// ===== hw/rtl/hdte_if.sv =====
interface hdte_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] char_byte;
    logic       last_char;

    modport source (output valid, output char_byte, output last_char, input ready);
    modport sink   (input valid, input char_byte, input last_char, output ready);
endinterface

interface hdte_out_if;
    logic              valid;
    logic              ready;
    logic              date_valid;
    logic signed [38:0] epoch_seconds;

    modport source (output valid, output date_valid, output epoch_seconds, input ready);
    modport sink   (input valid, input date_valid, input epoch_seconds, output ready);
endinterface

// ===== hw/rtl/hdte_ctrl.sv =====
`include "http_date_to_epoch_seconds_core_assert.svh"

module hdte_ctrl
    import hdte_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    input  logic      in_last,
    input  logic      out_ready,
    output logic      in_ready,
    output logic      out_valid,
    output hdte_cmd_t cmd
);

    hdte_state_t state_reg;
    hdte_state_t state_next;
    logic        out_valid_reg;
    logic        out_valid_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        in_ready   = 1'b0;
        cmd        = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready      = 1'b1;
                cmd.take_byte = in_valid;
                cmd.capture   = in_valid && in_last;
                if (in_valid && in_last)
                begin
                    state_next = ST_PREP;
                end
            end
            ST_PREP:
            begin
                cmd.prep   = 1'b1;
                state_next = ST_DIV;
            end
            ST_DIV:
            begin
                cmd.div    = 1'b1;
                state_next = ST_DAYS;
            end
            ST_DAYS:
            begin
                cmd.days   = 1'b1;
                state_next = ST_MUL;
            end
            ST_MUL:
            begin
                cmd.mul    = 1'b1;
                state_next = ST_SUM;
            end
            ST_SUM:
            begin
                // The result waits here until the output register is free.
                if (!out_valid_reg || out_ready)
                begin
                    cmd.load_out = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.load_out)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    assign out_valid = out_valid_reg;

    `HDTE_ASSERT_NXT(a_last_starts_calc, cmd.capture, state_reg == ST_PREP,
        "last byte did not start the date calculation")
    `HDTE_ASSERT_IMP(a_load_slot_free, cmd.load_out, !out_valid_reg || out_ready,
        "result loaded over an unread result")
    `HDTE_ASSERT_NXT(a_load_sets_valid, cmd.load_out, out_valid_reg,
        "loaded result not presented")

endmodule

// ===== hw/rtl/hdte_datapath.sv =====
module hdte_datapath
    import hdte_pkg::*;
#(
    parameter int MAX_YEAR = 9999
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  hdte_cmd_t          cmd,
    input  logic [7:0]         char_byte,
    output logic               date_valid,
    output logic [EPOCH_W-1:0] epoch_seconds
);

    localparam int YEAR_W  = $clog2(MAX_YEAR + 2);
    localparam int YPROD_W = YEAR_W + 4;
    localparam int QPROD_W = YEAR_W + 11;
    localparam int Y365_W  = YEAR_W + 9;
    localparam int DAYS_W  = YEAR_W + 10;
    localparam logic [YEAR_W-1:0] YEAR_SAT = YEAR_W'(MAX_YEAR + 1);
    localparam logic [YEAR_W-1:0] YEAR_MAX = YEAR_W'(MAX_YEAR);
    localparam logic [YEAR_W-1:0] YEAR_MIN = YEAR_W'(1601);

    // Token parser state.
    logic              comma_reg, comma_next;
    logic [2:0]        tok_num_reg, tok_num_next;
    logic              in_tok_reg, in_tok_next;
    logic [3:0]        tok_len_reg, tok_len_next;
    logic [5:0]        day_reg, day_next;
    logic [YEAR_W-1:0] year_reg, year_next;
    logic [23:0]       mon_reg, mon_next;
    logic [4:0]        hour_reg, hour_next;
    logic [5:0]        min_reg, min_next;
    logic [5:0]        sec_reg, sec_next;
    logic              zone_reg, zone_next;
    logic              err_reg, err_next;

    // Fields captured at the last byte.
    logic              cap_ok_reg;
    logic [YEAR_W-1:0] cap_year_reg;
    logic              cap_jf_reg;
    logic [3:0]        cap_shm_reg;
    logic [4:0]        cap_day_reg;
    logic [4:0]        cap_hour_reg;
    logic [5:0]        cap_min_reg;
    logic [5:0]        cap_sec_reg;

    // Date arithmetic stages.
    logic [YEAR_W-1:0]  y_reg, y_next;
    logic [TOD_W-1:0]   tod_reg, tod_next;
    logic [DOY_W-1:0]   doy_reg, doy_next;
    logic [YEAR_W-1:0]  q100_reg, q100_next;
    logic [QPROD_W-1:0] q_prod;
    logic [Y365_W-1:0]  y365_reg, y365_next;
    logic [DAYS_W-1:0]  days_reg, days_next;
    logic [EPOCH_W-1:0] days_ext;
    logic [EPOCH_W-1:0] prod_reg, prod_next;
    logic               out_ok_reg;
    logic [EPOCH_W-1:0] out_secs_reg, out_secs_next;

    logic [7:0]         lc;
    logic               is_dig;
    logic [3:0]         dig;
    logic               do_close;
    logic               do_feed;
    logic [3:0]         pos;
    logic [9:0]         day_prod;
    logic [YPROD_W-1:0] year_prod;
    logic [8:0]         hour_prod;
    logic [9:0]         min_prod;
    logic [9:0]         sec_prod;
    logic               fin_err;
    logic               fin_ok;
    hdte_month_t        mon_hit;

    always_comb
    begin
        comma_next   = comma_reg;
        tok_num_next = tok_num_reg;
        in_tok_next  = in_tok_reg;
        tok_len_next = tok_len_reg;
        day_next     = day_reg;
        year_next    = year_reg;
        mon_next     = mon_reg;
        hour_next    = hour_reg;
        min_next     = min_reg;
        sec_next     = sec_reg;
        zone_next    = zone_reg;
        err_next     = err_reg;
        do_close     = 1'b0;
        do_feed      = 1'b0;
        pos          = tok_len_reg;

        lc        = to_lower(char_byte);
        is_dig    = (char_byte >= CH_ZERO) && (char_byte <= CH_NINE);
        dig       = char_byte[3:0];
        day_prod  = 10'(day_reg) * 10'd10 + 10'(dig);
        year_prod = YPROD_W'(year_reg) * YPROD_W'(10) + YPROD_W'(dig);
        hour_prod = 9'(hour_reg) * 9'd10 + 9'(dig);
        min_prod  = 10'(min_reg) * 10'd10 + 10'(dig);
        sec_prod  = 10'(sec_reg) * 10'd10 + 10'(dig);

        if (cmd.take_byte)
        begin
            if (char_byte == CH_COMMA)
            begin
                if (!comma_reg)
                begin
                    // The first comma drops the weekday and anything it raised.
                    comma_next   = 1'b1;
                    tok_num_next = '0;
                    in_tok_next  = 1'b0;
                    tok_len_next = '0;
                    day_next     = '0;
                    year_next    = '0;
                    mon_next     = '0;
                    hour_next    = '0;
                    min_next     = '0;
                    sec_next     = '0;
                    zone_next    = 1'b0;
                    err_next     = 1'b0;
                end
                else
                begin
                    do_close = 1'b1;
                    err_next = 1'b1;
                end
            end
            else if (char_byte == CH_SPACE || char_byte == CH_TAB)
            begin
                do_close = 1'b1;
            end
            else if (!in_tok_reg && tok_num_reg >= 3'd5)
            begin
                err_next = 1'b1;
            end
            else
            begin
                do_feed = 1'b1;
                if (!in_tok_reg)
                begin
                    tok_num_next = tok_num_reg + 3'd1;
                    in_tok_next  = 1'b1;
                    pos          = '0;
                end
                tok_len_next = (pos == 4'd15) ? pos : pos + 4'd1;
            end
        end

        if (do_close && in_tok_reg)
        begin
            in_tok_next = 1'b0;
            if ((tok_num_reg == 3'd2 || tok_num_reg == 3'd5) && tok_len_reg != 4'd3)
            begin
                err_next = 1'b1;
            end
            if (tok_num_reg == 3'd4 && tok_len_reg != 4'd8)
            begin
                err_next = 1'b1;
            end
        end

        if (do_feed)
        begin
            case (tok_num_next)
                3'd1:
                begin
                    if (!is_dig)
                    begin
                        err_next = 1'b1;
                    end
                    else
                    begin
                        day_next = (day_prod > 10'd63) ? 6'd63 : day_prod[5:0];
                    end
                end
                3'd2:
                begin
                    case (pos)
                        4'd0: mon_next = mon_reg | {16'h0, lc};
                        4'd1: mon_next = mon_reg | {8'h0, lc, 8'h0};
                        4'd2: mon_next = mon_reg | {lc, 16'h0};
                        default: mon_next = mon_reg;
                    endcase
                end
                3'd3:
                begin
                    if (!is_dig)
                    begin
                        err_next = 1'b1;
                    end
                    else if (year_prod > YPROD_W'(YEAR_SAT))
                    begin
                        year_next = YEAR_SAT;
                    end
                    else
                    begin
                        year_next = year_prod[YEAR_W-1:0];
                    end
                end
                3'd4:
                begin
                    if (pos == 4'd2 || pos == 4'd5)
                    begin
                        if (char_byte != CH_COLON)
                        begin
                            err_next = 1'b1;
                        end
                    end
                    else if (pos < 4'd8)
                    begin
                        if (!is_dig)
                        begin
                            err_next = 1'b1;
                        end
                        else
                        begin
                            case (pos)
                                4'd0: hour_next = 5'(dig);
                                4'd1:
                                begin
                                    hour_next = hour_prod[4:0];
                                    if (hour_prod > 9'd23)
                                    begin
                                        err_next = 1'b1;
                                    end
                                end
                                4'd3: min_next = 6'(dig);
                                4'd4:
                                begin
                                    min_next = min_prod[5:0];
                                    if (min_prod > 10'd59)
                                    begin
                                        err_next = 1'b1;
                                    end
                                end
                                4'd6: sec_next = 6'(dig);
                                default:
                                begin
                                    sec_next = sec_prod[5:0];
                                    if (sec_prod > 10'd60)
                                    begin
                                        err_next = 1'b1;
                                    end
                                end
                            endcase
                        end
                    end
                end
                default:
                begin
                    case (pos)
                        4'd0: zone_next = (lc == ZONE_WORD[7:0]);
                        4'd1: zone_next = zone_reg && (lc == ZONE_WORD[15:8]);
                        4'd2: zone_next = zone_reg && (lc == ZONE_WORD[23:16]);
                        default: zone_next = zone_reg;
                    endcase
                end
            endcase
        end

        // Closing the final token and the range checks for the last byte.
        fin_err = err_next;
        if (in_tok_next)
        begin
            if ((tok_num_next == 3'd2 || tok_num_next == 3'd5) && tok_len_next != 4'd3)
            begin
                fin_err = 1'b1;
            end
            if (tok_num_next == 3'd4 && tok_len_next != 4'd8)
            begin
                fin_err = 1'b1;
            end
        end
        mon_hit = month_lookup(mon_next);
        fin_ok  = !fin_err && tok_num_next == 3'd5 && zone_next
                  && day_next >= 6'd1 && day_next <= 6'd31
                  && year_next >= YEAR_MIN && year_next <= YEAR_MAX
                  && mon_hit.hit;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            comma_reg   <= 1'b0;
            tok_num_reg <= '0;
            in_tok_reg  <= 1'b0;
            tok_len_reg <= '0;
            day_reg     <= '0;
            year_reg    <= '0;
            mon_reg     <= '0;
            hour_reg    <= '0;
            min_reg     <= '0;
            sec_reg     <= '0;
            zone_reg    <= 1'b0;
            err_reg     <= 1'b0;
        end
        else if (cmd.capture)
        begin
            comma_reg   <= 1'b0;
            tok_num_reg <= '0;
            in_tok_reg  <= 1'b0;
            tok_len_reg <= '0;
            day_reg     <= '0;
            year_reg    <= '0;
            mon_reg     <= '0;
            hour_reg    <= '0;
            min_reg     <= '0;
            sec_reg     <= '0;
            zone_reg    <= 1'b0;
            err_reg     <= 1'b0;
        end
        else
        begin
            comma_reg   <= comma_next;
            tok_num_reg <= tok_num_next;
            in_tok_reg  <= in_tok_next;
            tok_len_reg <= tok_len_next;
            day_reg     <= day_next;
            year_reg    <= year_next;
            mon_reg     <= mon_next;
            hour_reg    <= hour_next;
            min_reg     <= min_next;
            sec_reg     <= sec_next;
            zone_reg    <= zone_next;
            err_reg     <= err_next;
        end
    end

    // Arithmetic stages; y is the March-based year.
    always_comb
    begin
        y_next    = cap_year_reg - YEAR_W'(cap_jf_reg);
        tod_next  = TOD_W'(TOD_W'(cap_hour_reg) * TOD_W'(3600)
                    + TOD_W'(cap_min_reg) * TOD_W'(60) + TOD_W'(cap_sec_reg));
        doy_next  = DOY_START[cap_shm_reg] + DOY_W'(cap_day_reg) - DOY_W'(1);
        q_prod    = QPROD_W'(y_reg[YEAR_W-1:2]) * QPROD_W'(RECIP_25);
        q100_next = YEAR_W'(q_prod >> RECIP_SHIFT);
        y365_next = Y365_W'(y_reg) * Y365_W'(365);
        days_next = DAYS_W'(y365_reg) + DAYS_W'(y_reg >> 2) - DAYS_W'(q100_reg)
                    + DAYS_W'(q100_reg >> 2) + DAYS_W'(doy_reg) - DAYS_W'(EPOCH_DAY_OFS);
        days_ext  = {{(EPOCH_W - DAYS_W){days_reg[DAYS_W-1]}}, days_reg};
        prod_next = days_ext * EPOCH_W'(SECS_PER_DAY);
        out_secs_next = cap_ok_reg ? prod_reg + EPOCH_W'(tod_reg) : '0;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            cap_ok_reg   <= fin_ok;
            cap_year_reg <= year_next;
            cap_jf_reg   <= mon_hit.jan_feb;
            cap_shm_reg  <= mon_hit.shifted;
            cap_day_reg  <= day_next[4:0];
            cap_hour_reg <= hour_next;
            cap_min_reg  <= min_next;
            cap_sec_reg  <= sec_next;
        end
        if (cmd.prep)
        begin
            y_reg   <= y_next;
            tod_reg <= tod_next;
            doy_reg <= doy_next;
        end
        if (cmd.div)
        begin
            q100_reg <= q100_next;
            y365_reg <= y365_next;
        end
        if (cmd.days)
        begin
            days_reg <= days_next;
        end
        if (cmd.mul)
        begin
            prod_reg <= prod_next;
        end
        if (cmd.load_out)
        begin
            out_ok_reg   <= cap_ok_reg;
            out_secs_reg <= out_secs_next;
        end
    end

    assign date_valid    = out_ok_reg;
    assign epoch_seconds = out_secs_reg;

endmodule

// ===== hw/rtl/http_date_to_epoch_seconds_core.sv =====
// Timing: byte beats are accepted only while idle. After the beat with last_char
// is accepted, the prep, div, days, mul and sum steps run; sum loads the result.
// Throughput: one byte per cycle while idle; no byte is accepted during the five
// steps of the date arithmetic, and sum waits while an unread result is held.
// Reset: rst_n is asynchronous and active low; it empties the parser and the
// output register, and no result beat is pending after it.
module http_date_to_epoch_seconds_core
    import hdte_pkg::*;
#(
    parameter int MAX_YEAR = 9999
)
(
    input logic        clk,
    input logic        rst_n,
    hdte_in_if.sink    char_stream,
    hdte_out_if.source date_result
);

    // The controller sequences one string at a time: it lets bytes in while
    // idle, then steps the datapath through the calendar arithmetic and parks
    // the answer in the output register.
    hdte_cmd_t          cmd;
    logic               in_ready;
    logic               out_valid;
    logic               date_valid;
    logic [EPOCH_W-1:0] epoch_seconds;

    hdte_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (char_stream.valid),
        .in_last   (char_stream.last_char),
        .out_ready (date_result.ready),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .cmd       (cmd)
    );

    // The datapath parses every accepted byte, captures the parsed fields on
    // the last byte, and turns them into seconds since the epoch. Invalid
    // strings yield zero seconds with the valid flag low.
    hdte_datapath #(
        .MAX_YEAR (MAX_YEAR)
    ) u_datapath (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .char_byte     (char_stream.char_byte),
        .date_valid    (date_valid),
        .epoch_seconds (epoch_seconds)
    );

    // The output register lets a new string begin while the previous result
    // beat is still waiting to be taken.
    assign char_stream.ready         = in_ready;
    assign date_result.valid         = out_valid;
    assign date_result.date_valid    = date_valid;
    assign date_result.epoch_seconds = $signed(epoch_seconds);

endmodule

// ===== tb/testbench.sv =====
module testbench;
    import hdte_pkg::*;

    // The block is built with its default year ceiling; the checker uses the same bound.
    localparam int YEAR_LIMIT = 9999;

    // The random part stops once both of these are reached.
    localparam int MIN_BEATS = 1150;
    localparam int MIN_DATES = 36;

    localparam int N_DIRECTED = 28;

    typedef logic [7:0] char_t;
    typedef char_t char_q_t[$];

    // One decoded date, as the result channel should present it.
    typedef struct {
        bit                 ok;
        logic signed [38:0] secs;
    } stamp_t;

    // One directed string. When pinned is set, the expected result is the
    // typed-in pair rather than the one the checker computes.
    typedef struct {
        string  txt;
        bit     pinned;
        bit     ok;
        longint secs;
    } date_case_t;

    logic clk;
    logic rst_n;

    hdte_in_if  char_if ();
    hdte_out_if res_if ();

    http_date_to_epoch_seconds_core #(
        .MAX_YEAR (YEAR_LIMIT)
    ) dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .char_stream (char_if),
        .date_result (res_if)
    );

    // Directed strings: the well-known instants, the ends of the legal range
    // and one string for each way a date can be rejected. Rows with the
    // pinned flag clear are checked against the computed expectation only.
    date_case_t directed_dates [N_DIRECTED] = '{
        '{"Thu, 01 Jan 1970 00:00:00 GMT",        1'b1, 1'b1, 64'sd0},
        '{"Mon, 01 Jan 1601 00:00:00 GMT",        1'b1, 1'b1, -64'sd11644473600},
        '{"Fri, 31 Dec 9999 23:59:60 GMT",        1'b1, 1'b1, 64'sd253402300800},
        '{"Sun, 06 Nov 1994 08:49:37 GMT",        1'b1, 1'b1, 64'sd784111777},
        '{"06 nOV 1994 08:49:37 gmt",             1'b0, 1'b0, 64'sd0},
        '{"Xyz 12 Foo, 29 feb 2000\t12:00:00 gmT", 1'b0, 1'b0, 64'sd0},
        '{"Sun, 06 Nov, 1994 08:49:37 GMT",       1'b1, 1'b0, 64'sd0},
        '{"Sun, 0x Nov 1994 08:49:37 GMT",        1'b1, 1'b0, 64'sd0},
        '{"Sun, 06 Nov 19a4 08:49:37 GMT",        1'b1, 1'b0, 64'sd0},
        '{"Sun, 999999 Nov 1994 08:49:37 GMT",    1'b1, 1'b0, 64'sd0},
        '{"Sun, 06 Nov 99999999 08:49:37 GMT",    1'b1, 1'b0, 64'sd0},
        '{"Sun, 06 Novem 1994 08:49:37 GMT",      1'b1, 1'b0, 64'sd0},
        '{"Sun, 06 Nov 1994 8:49:37 GMT",         1'b1, 1'b0, 64'sd0},
        '{"Sun, 06 Nov 1994 08-49:37 GMT",        1'b1, 1'b0, 64'sd0},
        '{"Sun, 06 Nov 1994 08:49:37 GMTX",       1'b1, 1'b0, 64'sd0},
        '{"Sun, 00 Nov 1994 08:49:37 GMT",        1'b1, 1'b0, 64'sd0},
        '{"Sun, 32 Oct 1994 08:49:37 GMT",        1'b1, 1'b0, 64'sd0},
        '{"Sun, 06 Nov 1600 08:49:37 GMT",        1'b1, 1'b0, 64'sd0},
        '{"Sun, 06 Nov 10000 08:49:37 GMT",       1'b1, 1'b0, 64'sd0},
        '{"Sun, 06 Nov 1994 24:00:00 GMT",        1'b1, 1'b0, 64'sd0},
        '{"Sun, 06 Nov 1994 23:60:00 GMT",        1'b1, 1'b0, 64'sd0},
        '{"Sun, 06 Nov 1994 23:59:61 GMT",        1'b1, 1'b0, 64'sd0},
        '{"Tue, 31 Feb 2001 00:00:00 GMT",        1'b0, 1'b0, 64'sd0},
        '{"Sun, 06 Nov 1994 08:49:37",            1'b1, 1'b0, 64'sd0},
        '{"Sun, 06 Nov 1994 08:49:37 GMT GMT",    1'b1, 1'b0, 64'sd0},
        '{",",                                    1'b1, 1'b0, 64'sd0},
        '{"Sun, 06 Nov 1994 08:49:37 UTC",        1'b1, 1'b0, 64'sd0},
        '{"\t0006   aUg  002024 00:00:00\tGmT ",   1'b0, 1'b0, 64'sd0}
    };

    // Parser state of the checker. It mirrors what the block keeps between
    // byte beats and is cleared after every closing beat.
    bit             after_comma = 1'b0;
    int unsigned    tok_count   = 0;
    bit             in_word     = 1'b0;
    int unsigned    word_len    = 0;
    int unsigned    day_acc     = 0;
    int unsigned    year_acc    = 0;
    logic [23:0]    month_acc   = '0;
    logic [16:0]    clock_acc   = '0;
    bit             zone_ok     = 1'b0;
    bit             malformed   = 1'b0;

    // Dates whose closing beat has been accepted but whose result has not.
    stamp_t stamps_due[$];

    int mismatch_count = 0;
    int beats_sent     = 0;
    int dates_closed   = 0;
    int burst_left     = 0;
    int gap_ceiling    = 3;

    logic [15:0] stall_pat = 16'hFFFF;
    int          stall_age = 0;

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // Hard stop, far beyond the slowest correct run.
    initial
    begin
        #400000;
        $display("Test completed with failures");
        $finish;
    end

    // ------------------------------------------------------------------
    // Checker: parses the byte stream the same way the block must.
    // ------------------------------------------------------------------

    function automatic void clear_fields();
        tok_count = 0;
        in_word   = 1'b0;
        word_len  = 0;
        day_acc   = 0;
        year_acc  = 0;
        month_acc = '0;
        clock_acc = '0;
        zone_ok   = 1'b0;
        malformed = 1'b0;
    endfunction

    // A token ends at a separator, a stray comma or the closing beat. Only
    // then can its length be judged: month and zone need three bytes, the
    // time of day eight.
    function automatic void close_word();
        if (!in_word)
            return;
        in_word = 1'b0;
        if ((tok_count == 2 || tok_count == 5) && word_len != 3)
            malformed = 1'b1;
        if (tok_count == 4 && word_len != 8)
            malformed = 1'b1;
    endfunction

    // The time of day is packed as hour[16:12], minute[11:6], second[5:0].
    // The first digit of a pair is stored as is; the second one completes the
    // pair and is range checked.
    function automatic void clock_digit(int unsigned pos, int unsigned d);
        int unsigned shift;
        int unsigned mask;
        int unsigned limit;
        int unsigned v;
        int unsigned bits;
        shift = (pos < 2) ? 12 : (pos < 5) ? 6 : 0;
        mask  = (pos < 2) ? 'h1F : 'h3F;
        limit = (pos < 2) ? 23 : (pos < 5) ? 59 : 60;
        bits  = clock_acc;
        if (pos == 0 || pos == 3 || pos == 6)
        begin
            v = d;
        end
        else
        begin
            v = ((bits >> shift) & mask) * 10 + d;
            if (v > limit)
                malformed = 1'b1;
        end
        bits = (bits & ~(mask << shift)) | ((v & mask) << shift);
        clock_acc = bits[16:0];
    endfunction

    function automatic void feed_word(char_t c, int unsigned pos);
        string       zone = "gmt";
        char_t       lc;
        bit          is_dig;
        bit          m;
        int unsigned d;
        lc     = (c >= "A" && c <= "Z") ? c + 8'd32 : c;
        is_dig = (c >= CH_ZERO && c <= CH_NINE);
        d      = c - CH_ZERO;
        case (tok_count)
            1:
            begin
                if (!is_dig)
                begin
                    malformed = 1'b1;
                end
                else
                begin
                    day_acc = day_acc * 10 + d;
                    if (day_acc > 63)
                        day_acc = 63;
                end
            end
            2:
            begin
                if (pos < 3)
                    month_acc[8*pos +: 8] = lc;
            end
            3:
            begin
                if (!is_dig)
                begin
                    malformed = 1'b1;
                end
                else
                begin
                    year_acc = year_acc * 10 + d;
                    if (year_acc > YEAR_LIMIT + 1)
                        year_acc = YEAR_LIMIT + 1;
                end
            end
            4:
            begin
                if (pos < 8)
                begin
                    if (pos == 2 || pos == 5)
                    begin
                        if (c != CH_COLON)
                            malformed = 1'b1;
                    end
                    else if (!is_dig)
                    begin
                        malformed = 1'b1;
                    end
                    else
                    begin
                        clock_digit(pos, d);
                    end
                end
            end
            default:
            begin
                if (pos < 3)
                begin
                    m = (lc == zone[pos]);
                    zone_ok = (pos == 0) ? m : (zone_ok && m);
                end
            end
        endcase
    endfunction

    // Takes one byte. The first comma throws away whatever came before it,
    // errors included; any later comma spoils the date. A sixth token is an
    // error and its bytes are otherwise dropped.
    function automatic void absorb_char(char_t c);
        if (c == CH_COMMA)
        begin
            if (!after_comma)
            begin
                after_comma = 1'b1;
                clear_fields();
            end
            else
            begin
                close_word();
                malformed = 1'b1;
            end
        end
        else if (c == CH_SPACE || c == CH_TAB)
        begin
            close_word();
        end
        else
        begin
            if (!in_word)
            begin
                if (tok_count >= 5)
                begin
                    malformed = 1'b1;
                    return;
                end
                tok_count++;
                in_word  = 1'b1;
                word_len = 0;
            end
            feed_word(c, word_len);
            if (word_len < 15)
                word_len++;
        end
    endfunction

    // Day count from the civil calendar, with the year starting in March so
    // that the leap day falls at its end. Years here are always positive.
    function automatic longint days_from_civil(longint year, longint mon, longint day);
        longint y;
        longint era;
        longint yoe;
        longint doy;
        longint doe;
        y   = (mon <= 2) ? year - 1 : year;
        era = y / 400;
        yoe = y - era * 400;
        doy = (153 * ((mon > 2) ? mon - 3 : mon + 9) + 2) / 5 + day - 1;
        doe = yoe * 365 + yoe / 4 - yoe / 100 + doy;
        return era * 146097 + doe - EPOCH_DAY_OFS;
    endfunction

    // Called for the closing beat after its byte has been taken.
    function automatic stamp_t close_date();
        string  names = "janfebmaraprmayjunjulaugsepoctnovdec";
        stamp_t r;
        int     mon;
        longint hh;
        longint mm;
        longint ss;
        close_word();
        mon = 0;
        for (int i = 0; i < 12; i++)
        begin
            if (month_acc == {names[3*i+2], names[3*i+1], names[3*i]})
                mon = i + 1;
        end
        r.ok = !malformed && tok_count == 5 && zone_ok
               && day_acc >= 1 && day_acc <= 31
               && year_acc >= 1601 && year_acc <= YEAR_LIMIT && mon != 0;
        r.secs = '0;
        if (r.ok)
        begin
            hh = clock_acc[16:12];
            mm = clock_acc[11:6];
            ss = clock_acc[5:0];
            r.secs = 39'(days_from_civil(year_acc, mon, day_acc) * SECS_PER_DAY
                          + hh * 3600 + mm * 60 + ss);
        end
        after_comma = 1'b0;
        clear_fields();
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Stimulus generation.
    // ------------------------------------------------------------------

    function automatic void put_num(ref char_q_t q, input int unsigned v, input int w);
        string s;
        s = $sformatf("%0d", v);
        while (s.len() < w)
            s = {"0", s};
        for (int i = 0; i < s.len(); i++)
            q.push_back(s[i]);
    endfunction

    // Usually a single blank; sometimes a run of up to three. Each is a tab or a space.
    function automatic void put_gap(ref char_q_t q, input int min_n);
        int n;
        n = ($urandom_range(0, 4) == 0) ? $urandom_range(min_n, 3) : 1;
        repeat (n)
            q.push_back(($urandom_range(0, 3) == 0) ? CH_TAB : CH_SPACE);
    endfunction

    // Appends a lower-case word with each letter in random case.
    function automatic void put_word(ref char_q_t q, input string s);
        char_t c;
        for (int i = 0; i < s.len(); i++)
        begin
            c = s[i];
            if (c >= "a" && c <= "z" && $urandom_range(0, 1) == 1)
                c = c - 8'd32;
            q.push_back(c);
        end
    endfunction

    function automatic void put_junk(ref char_q_t q, input int n);
        string s;
        s = "";
        repeat (n)
            s = {s, string'(char_t'($urandom_range(97, 122)))};
        put_word(q, s);
    endfunction

    // Builds one string. Most are well-formed dates with random content,
    // with a small share of out-of-range fields, wrong lengths and damaged
    // bytes; a few are plain noise.
    function automatic void compose_date(ref char_q_t q);
        string       wdays  = "montuewedthufrisatsun";
        string       months = "janfebmaraprmayjunjulaugsepoctnovdec";
        int          pick;
        int          k;
        int          pos;
        int unsigned hh;
        int unsigned mm;
        int unsigned ss;
        char_t       sep;
        q.delete();
        pick = $urandom_range(0, 99);
        if (pick < 8)
        begin
            repeat ($urandom_range(1, 24))
                q.push_back(char_t'($urandom_range(0, 255)));
            return;
        end

        // Optional weekday, or a few throwaway tokens, before the comma.
        pick = $urandom_range(0, 5);
        if (pick == 1)
        begin
            repeat ($urandom_range(1, 3))
            begin
                put_junk(q, $urandom_range(1, 4));
                put_gap(q, 1);
            end
            q.push_back(CH_COMMA);
        end
        else if (pick > 1)
        begin
            k = $urandom_range(0, 6);
            put_word(q, wdays.substr(3*k, 3*k + 2));
            q.push_back(CH_COMMA);
        end
        put_gap(q, 0);

        pick = $urandom_range(0, 19);
        if (pick == 0)
            put_num(q, $urandom_range(0, 99), 2);
        else if (pick == 1)
            put_num(q, $urandom_range(100, 999999), 1);
        else if (pick == 2)
            put_junk(q, 2);
        else
            put_num(q, $urandom_range(1, 31), $urandom_range(1, 2));
        put_gap(q, 1);

        if ($urandom_range(0, 19) == 0)
        begin
            put_junk(q, $urandom_range(1, 5));
        end
        else
        begin
            k = $urandom_range(0, 11);
            put_word(q, months.substr(3*k, 3*k + 2));
        end
        put_gap(q, 1);

        pick = $urandom_range(0, 19);
        case (pick)
            0:       put_num(q, 1601, 4);
            1:       put_num(q, 9999, 4);
            2:       put_num(q, 1600, 4);
            3:       put_num(q, 10000, 5);
            4:       put_num(q, $urandom_range(0, 99999), 1);
            5:       put_num(q, $urandom_range(1601, 9999), 6);
            default: put_num(q, $urandom_range(1601, 9999), 4);
        endcase
        put_gap(q, 1);

        if ($urandom_range(0, 9) == 0)
        begin
            hh = $urandom_range(0, 99);
            mm = $urandom_range(0, 99);
            ss = $urandom_range(0, 99);
        end
        else
        begin
            hh = $urandom_range(0, 23);
            mm = $urandom_range(0, 59);
            ss = $urandom_range(0, 60);
        end
        sep = ($urandom_range(0, 29) == 0) ? "-" : CH_COLON;
        put_num(q, hh, ($urandom_range(0, 29) == 0) ? 1 : 2);
        q.push_back(sep);
        put_num(q, mm, 2);
        q.push_back(CH_COLON);
        put_num(q, ss, 2);
        put_gap(q, 1);

        pick = $urandom_range(0, 14);
        if (pick == 0)
            put_junk(q, 3);
        else if (pick == 1)
            put_word(q, "gmtt");
        else
            put_word(q, "gmt");
        if ($urandom_range(0, 3) == 0)
            put_gap(q, 1);
        if ($urandom_range(0, 24) == 0)
            put_junk(q, 2);

        // Occasional damage anywhere in the string.
        if ($urandom_range(0, 9) == 0)
        begin
            pos = $urandom_range(0, q.size() - 1);
            case ($urandom_range(0, 3))
                0:       q[pos] = char_t'($urandom_range(0, 255));
                1:       q.delete(pos);
                2:       q.insert(pos, char_t'($urandom_range(0, 255)));
                default: q.insert(pos, CH_COMMA);
            endcase
        end
        if (q.size() == 0)
            q.push_back(char_t'($urandom_range(0, 255)));
    endfunction

    // ------------------------------------------------------------------
    // Byte channel driver.
    // ------------------------------------------------------------------

    // Presents one byte beat and returns at the edge where it is accepted.
    // The sender works in bursts; valid drops only before a nonzero gap of idle
    // cycles, so it is never lowered and raised in the same step.
    task automatic send_char(char_t c, bit last);
        int gap;
        if (burst_left == 0)
        begin
            gap = $urandom_range(0, gap_ceiling);
            if (gap > 0)
            begin
                char_if.valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = $urandom_range(1, 40);
        end
        char_if.valid     <= 1'b1;
        char_if.char_byte <= c;
        char_if.last_char <= last;
        do
            @(posedge clk);
        while (!char_if.ready);
        burst_left--;
        beats_sent++;
    endtask

    // Sends a whole string, the last byte marked, and records what its
    // closing beat must produce.
    task automatic send_date(char_q_t q, bit pinned, bit ok, longint secs);
        stamp_t s;
        for (int i = 0; i < q.size(); i++)
        begin
            send_char(q[i], i == q.size() - 1);
            absorb_char(q[i]);
            if (i == q.size() - 1)
            begin
                s = close_date();
                if (pinned)
                begin
                    s.ok   = ok;
                    s.secs = 39'(secs);
                end
                stamps_due.push_back(s);
                dates_closed++;
            end
        end
    endtask

    // Holds the byte channel quiet until every pending result has arrived.
    task automatic drain_results();
        char_if.valid <= 1'b0;
        do
            @(posedge clk);
        while (stamps_due.size() != 0);
        burst_left = 0;
    endtask

    task automatic report(string what);
        mismatch_count++;
        $display("[%0t] MISMATCH: %s", $time, what);
    endtask

    // ------------------------------------------------------------------
    // Result channel: stall pattern and checking.
    // ------------------------------------------------------------------

    // The receiver follows a rotating 16-bit ready pattern that is redrawn whenever
    // its age counter runs out. A quarter of the patterns never stall, and
    // every pattern has at least one ready cycle in it.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (stall_age == 0)
            begin
                stall_age = $urandom_range(40, 160);
                stall_pat = ($urandom_range(0, 3) == 0) ? 16'hFFFF
                                                        : (16'($urandom) | 16'h0001);
            end
            stall_age--;
            res_if.ready <= stall_pat[0];
            stall_pat = {stall_pat[0], stall_pat[15:1]};
        end
    end

    // Every accepted result beat is matched against the oldest pending date.
    always @(posedge clk)
    begin
        stamp_t want;
        if (rst_n && res_if.valid && res_if.ready)
        begin
            if (stamps_due.size() == 0)
            begin
                report("result beat with no date pending");
            end
            else
            begin
                want = stamps_due.pop_front();
                if (res_if.date_valid !== want.ok)
                    report($sformatf("date_valid %0b, expected %0b",
                                     res_if.date_valid, want.ok));
                if (res_if.epoch_seconds !== want.secs)
                    report($sformatf("epoch_seconds %0d, expected %0d",
                                     res_if.epoch_seconds, want.secs));
            end
        end
    end

    // ------------------------------------------------------------------
    // Test sequence.
    // ------------------------------------------------------------------

    initial
    begin
        char_q_t chars;
        int      n_random;
        rst_n             = 1'b0;
        char_if.valid     = 1'b0;
        char_if.char_byte = '0;
        char_if.last_char = 1'b0;
        res_if.ready      = 1'b0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        // Directed strings, sent back to back with light idling.
        for (int i = 0; i < N_DIRECTED; i++)
        begin
            chars.delete();
            for (int k = 0; k < directed_dates[i].txt.len(); k++)
                chars.push_back(directed_dates[i].txt[k]);
            send_date(chars, directed_dates[i].pinned, directed_dates[i].ok,
                      directed_dates[i].secs);
        end
        drain_results();

        // Random strings. The sender idling changes every dozen strings,
        // including stretches with none at all, and once in the middle the
        // sender waits for the result channel to empty.
        n_random = 0;
        while (beats_sent < MIN_BEATS || dates_closed < MIN_DATES)
        begin
            if (n_random % 12 == 0)
            begin
                case ($urandom_range(0, 2))
                    0:       gap_ceiling = 0;
                    1:       gap_ceiling = 3;
                    default: gap_ceiling = 10;
                endcase
            end
            if (n_random == 6)
                drain_results();
            compose_date(chars);
            send_date(chars, 1'b0, 1'b0, 64'sd0);
            n_random++;
        end

        // Let the last results come out, then allow a few spare cycles for
        // anything the block should not have produced.
        drain_results();
        repeat (12) @(posedge clk);
        if (mismatch_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
